/* sv/vbap_triplet_gains_defines.svh */
// Assertion macros for the triplet gain block
`ifndef VBAP_TRIPLET_GAINS_DEFINES_SVH
`define VBAP_TRIPLET_GAINS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define VBT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define VBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/vbt_pkg.sv */
// Shared types and constants for the triplet gain pipeline
`default_nettype none
package vbt_pkg;
    localparam int COEF_BITS_DEF   = 18;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int NORM_TOP        = 30;
    localparam int SUM_W           = 2 * NORM_TOP + 2;
    localparam int SQ_W            = SUM_W + 1;
    localparam int SQ_STEPS        = SUM_W / 2;
    localparam int ROOT_W          = SQ_STEPS;

    typedef enum logic [1:0] {
        REG_ROW_X = 2'd0,
        REG_ROW_Y = 2'd1,
        REG_ROW_Z = 2'd2,
        REG_TOL   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][NORM_TOP-1:0] mag;
        logic [2:0]               neg;
        logic                     ok;
    } side_t;
endpackage
`default_nettype wire

/* sv/vbt_front.sv */
// Matrix product, region test, magnitude normalization and sum of squares
`default_nettype none
module vbt_front import vbt_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [SAMPLE_BITS-1:0] dir_x,
    input  wire logic signed [SAMPLE_BITS-1:0] dir_y,
    input  wire logic signed [SAMPLE_BITS-1:0] dir_z,
    input  wire logic [3*COEF_BITS-1:0]        row_x,
    input  wire logic [3*COEF_BITS-1:0]        row_y,
    input  wire logic [3*COEF_BITS-1:0]        row_z,
    input  wire logic [14:0]                   tol,
    output logic                               out_valid,
    output side_t                              out_side,
    output logic [SUM_W-1:0]                   out_sum
);
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int RAW_W  = SAMPLE_BITS + COEF_BITS + 2;
    localparam int MAG_W  = RAW_W;
    localparam int FRAC   = (SAMPLE_BITS - 1) + (COEF_BITS - 4);
    localparam int LEN_W  = $clog2(MAG_W + 1);
    localparam int SH_W   = (MAG_W > NORM_TOP) ? MAG_W : NORM_TOP;

    logic signed [SAMPLE_BITS-1:0] dirs [3];
    logic [3*COEF_BITS-1:0]        rows [3];
    logic signed [PROD_W-1:0]      prod_next [3][3];
    logic signed [PROD_W-1:0]      prod_reg  [3][3];
    logic signed [RAW_W-1:0]       raw_next [3];
    logic signed [RAW_W-1:0]       raw_reg  [3];
    logic signed [RAW_W-1:0]       tol_s;
    logic [MAG_W-1:0]              mag_next [3];
    logic [MAG_W-1:0]              mag3_reg [3];
    logic [MAG_W-1:0]              max_next;
    logic [MAG_W-1:0]              max3_reg;
    logic [2:0]                    neg_next;
    logic [2:0]                    neg3_reg, neg4_reg, neg5_reg, neg6_reg, neg7_reg;
    logic                          rej_next;
    logic                          ok3_reg, ok4_reg, ok5_reg, ok6_reg, ok7_reg;
    logic [MAG_W-1:0]              mag4_reg [3];
    logic [LEN_W-1:0]              len_next, amt_next, amt_reg;
    logic                          right_next, right_reg;
    logic [SH_W-1:0]               sh_tmp [3];
    logic [2:0][NORM_TOP-1:0]      scaled_next;
    logic [2:0][NORM_TOP-1:0]      scaled5_reg, scaled6_reg, scaled7_reg;
    logic [2*NORM_TOP-1:0]         sq_reg [3];
    logic [SUM_W-1:0]              sum_reg;
    logic [6:0]                    v_reg;

    // stage 1: nine products
    always_comb begin
        dirs[0] = dir_x;
        dirs[1] = dir_y;
        dirs[2] = dir_z;
        rows[0] = row_x;
        rows[1] = row_y;
        rows[2] = row_z;
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
                prod_next[r][i] = dirs[r] * $signed(rows[r][i*COEF_BITS +: COEF_BITS]);
            end
        end
    end

    // stage 2: raw gains
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            raw_next[i] = RAW_W'(prod_reg[0][i]) + RAW_W'(prod_reg[1][i])
                        + RAW_W'(prod_reg[2][i]);
        end
    end

    // stage 3: region test, magnitudes, largest magnitude
    always_comb begin
        tol_s    = $signed(RAW_W'(tol) << (FRAC - 15));
        rej_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            neg_next[i] = raw_reg[i][RAW_W-1];
            mag_next[i] = neg_next[i] ? MAG_W'(-raw_reg[i]) : MAG_W'(raw_reg[i]);
            if (raw_reg[i] < -tol_s) rej_next = 1'b1;
        end
        max_next = mag_next[0];
        if (mag_next[1] > max_next) max_next = mag_next[1];
        if (mag_next[2] > max_next) max_next = mag_next[2];
    end

    // stage 4: bit length of the largest magnitude sets a common shift
    always_comb begin
        len_next = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (max3_reg[k]) len_next = LEN_W'(k + 1);
        end
        right_next = (len_next > LEN_W'(NORM_TOP));
        amt_next   = right_next ? (len_next - LEN_W'(NORM_TOP))
                                : (LEN_W'(NORM_TOP) - len_next);
    end

    // stage 5: apply the shift
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sh_tmp[i] = right_reg ? (SH_W'(mag4_reg[i]) >> amt_reg)
                                  : (SH_W'(mag4_reg[i]) << amt_reg);
            scaled_next[i] = sh_tmp[i][NORM_TOP-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= prod_next;
            raw_reg     <= raw_next;
            mag3_reg    <= mag_next;
            max3_reg    <= max_next;
            neg3_reg    <= neg_next;
            ok3_reg     <= !rej_next;
            mag4_reg    <= mag3_reg;
            amt_reg     <= amt_next;
            right_reg   <= right_next;
            neg4_reg    <= neg3_reg;
            ok4_reg     <= ok3_reg && (max3_reg != '0);
            scaled5_reg <= scaled_next;
            neg5_reg    <= neg4_reg;
            ok5_reg     <= ok4_reg;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= scaled5_reg[i] * scaled5_reg[i];
            end
            scaled6_reg <= scaled5_reg;
            neg6_reg    <= neg5_reg;
            ok6_reg     <= ok5_reg;
            sum_reg     <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            scaled7_reg <= scaled6_reg;
            neg7_reg    <= neg6_reg;
            ok7_reg     <= ok6_reg;
        end
    end

    assign out_valid    = v_reg[6];
    assign out_sum      = sum_reg;
    assign out_side.mag = scaled7_reg;
    assign out_side.neg = neg7_reg;
    assign out_side.ok  = ok7_reg;
endmodule
`default_nettype wire

/* sv/vbt_sqrt.sv */
// Pipelined integer square root, one result bit per stage
`default_nettype none
module vbt_sqrt import vbt_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire side_t            in_side,
    input  wire logic [SUM_W-1:0] in_sum,
    output logic                  out_valid,
    output side_t                 out_side,
    output logic [ROOT_W-1:0]     out_root
);
    logic [SQ_W-1:0] x_reg [SQ_STEPS];
    logic [SQ_W-1:0] r_reg [SQ_STEPS];
    logic [SQ_W-1:0] x_next [SQ_STEPS];
    logic [SQ_W-1:0] r_next [SQ_STEPS];
    side_t           side_reg [SQ_STEPS];
    logic [SQ_STEPS-1:0] v_reg;

    always_comb begin
        logic [SQ_W-1:0] xi, ri, bitv, t;
        for (int j = 0; j < SQ_STEPS; j++) begin
            xi   = (j == 0) ? SQ_W'(in_sum) : x_reg[(j == 0) ? 0 : j - 1];
            ri   = (j == 0) ? '0 : r_reg[(j == 0) ? 0 : j - 1];
            bitv = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
            t    = ri + bitv;
            if (xi >= t) begin
                x_next[j] = xi - t;
                r_next[j] = (ri >> 1) + bitv;
            end else begin
                x_next[j] = xi;
                r_next[j] = ri >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[SQ_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg       <= x_next;
            r_reg       <= r_next;
            side_reg[0] <= in_side;
            for (int j = 1; j < SQ_STEPS; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = v_reg[SQ_STEPS-1];
    assign out_side  = side_reg[SQ_STEPS-1];
    assign out_root  = r_reg[SQ_STEPS-1][ROOT_W-1:0];
endmodule
`default_nettype wire

/* sv/vbt_div.sv */
// Pipelined rounded division of three magnitudes by the norm, one quotient bit per stage after the prep stage
`default_nettype none
module vbt_div import vbt_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire side_t                  in_side,
    input  wire logic [ROOT_W-1:0]      in_root,
    output logic                        out_valid,
    output side_t                       out_side,
    output logic [2:0][SAMPLE_BITS-1:0] out_quo
);
    localparam int RW     = NORM_TOP + SAMPLE_BITS + 1;
    localparam int DW     = ROOT_W + 1;
    localparam int TW     = DW + SAMPLE_BITS;
    localparam int STAGES = SAMPLE_BITS + 1;

    logic [RW-1:0]                rem_reg  [STAGES][3];
    logic [RW-1:0]                rem_next [STAGES][3];
    logic [2:0][SAMPLE_BITS-1:0]  q_reg    [STAGES];
    logic [2:0][SAMPLE_BITS-1:0]  q_next   [STAGES];
    logic [DW-1:0]                d_reg    [STAGES];
    side_t                        side_reg [STAGES];
    logic [STAGES-1:0]            v_reg;

    always_comb begin
        logic [TW-1:0] trial;
        for (int l = 0; l < 3; l++) begin
            // prep: numerator with half the divisor added for rounding
            rem_next[0][l] = (RW'(in_side.mag[l]) << SAMPLE_BITS) + RW'(in_root);
            q_next[0][l]   = '0;
        end
        for (int j = 1; j < STAGES; j++) begin
            trial = TW'(d_reg[j-1]) << (SAMPLE_BITS - j);
            for (int l = 0; l < 3; l++) begin
                q_next[j][l] = q_reg[j-1][l];
                if (TW'(rem_reg[j-1][l]) >= trial) begin
                    rem_next[j][l] = rem_reg[j-1][l] - trial[RW-1:0];
                    q_next[j][l][SAMPLE_BITS-j] = 1'b1;
                end else begin
                    rem_next[j][l] = rem_reg[j-1][l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg     <= rem_next;
            q_reg       <= q_next;
            d_reg[0]    <= {in_root, 1'b0};
            side_reg[0] <= in_side;
            for (int j = 1; j < STAGES; j++) begin
                d_reg[j]    <= d_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_quo   = q_reg[STAGES-1];
endmodule
`default_nettype wire

/* sv/vbap_triplet_gains.sv */
// Pipeline from accepted word to result:
// 7 front stages, 31 square-root stages, SAMPLE_BITS + 1 divider stages, 1 output stage.
// Throughput: one word per cycle; a stall on the result side freezes the whole pipeline.
// Reset: synchronous active-low aresetn clears valid bits and config registers to zero.
`default_nettype none
module vbap_triplet_gains import vbt_pkg::*; #(
    parameter int COEF_BITS   = COEF_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [3*COEF_BITS-1:0]        cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_dir_x,
    input  wire logic signed [SAMPLE_BITS-1:0] s_dir_y,
    input  wire logic signed [SAMPLE_BITS-1:0] s_dir_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_gain_first,
    output logic signed [SAMPLE_BITS-1:0]      m_gain_second,
    output logic signed [SAMPLE_BITS-1:0]      m_gain_third,
    output logic                               m_inside_region
);
    `include "vbap_triplet_gains_defines.svh"

    logic [3*COEF_BITS-1:0] row_x_reg, row_y_reg, row_z_reg;
    logic [14:0]            tol_reg;
    logic                   en;

    logic                   fr_valid, sq_valid, dv_valid;
    side_t                  fr_side, sq_side, dv_side;
    logic [SUM_W-1:0]       fr_sum;
    logic [ROOT_W-1:0]      sq_root;
    logic [2:0][SAMPLE_BITS-1:0] dv_quo;

    logic [2:0][SAMPLE_BITS-1:0] gain_next;
    logic [2:0][SAMPLE_BITS-1:0] gain_reg;
    logic                   inside_reg, m_valid_reg;

    // advance everything unless a finished word is waiting
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_x_reg <= '0;
            row_y_reg <= '0;
            row_z_reg <= '0;
            tol_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_ROW_X: row_x_reg <= cfg_wdata;
                REG_ROW_Y: row_y_reg <= cfg_wdata;
                REG_ROW_Z: row_z_reg <= cfg_wdata;
                REG_TOL:   tol_reg   <= cfg_wdata[14:0];
                default:   ;
            endcase
        end
    end

    vbt_front #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEF_BITS  (COEF_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid && s_ready),
        .dir_x    (s_dir_x),
        .dir_y    (s_dir_y),
        .dir_z    (s_dir_z),
        .row_x    (row_x_reg),
        .row_y    (row_y_reg),
        .row_z    (row_z_reg),
        .tol      (tol_reg),
        .out_valid(fr_valid),
        .out_side (fr_side),
        .out_sum  (fr_sum)
    );

    vbt_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (fr_valid),
        .in_side  (fr_side),
        .in_sum   (fr_sum),
        .out_valid(sq_valid),
        .out_side (sq_side),
        .out_root (sq_root)
    );

    vbt_div #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (sq_valid),
        .in_side  (sq_side),
        .in_root  (sq_root),
        .out_valid(dv_valid),
        .out_side (dv_side),
        .out_quo  (dv_quo)
    );

    // saturate full scale, restore sign, zero when outside or degenerate
    always_comb begin
        logic [SAMPLE_BITS-1:0] q;
        for (int l = 0; l < 3; l++) begin
            q = dv_quo[l];
            if (q[SAMPLE_BITS-1]) q = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            if (!dv_side.ok) begin
                gain_next[l] = '0;
            end else begin
                gain_next[l] = dv_side.neg[l] ? (~q + 1'b1) : q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gain_reg   <= gain_next;
            inside_reg <= dv_side.ok;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_gain_first    = gain_reg[0];
    assign m_gain_second   = gain_reg[1];
    assign m_gain_third    = gain_reg[2];
    assign m_inside_region = inside_reg;

    `VBT_ASSERT_IMPL(a_outside_zero, m_valid && !m_inside_region,
        (m_gain_first == '0) && (m_gain_second == '0) && (m_gain_third == '0),
        "outside word carries nonzero gain")
    `VBT_ASSERT_IMPL(a_no_min_code, m_valid && m_inside_region,
        (m_gain_first != {1'b1, {(SAMPLE_BITS-1){1'b0}}})
        && (m_gain_second != {1'b1, {(SAMPLE_BITS-1){1'b0}}})
        && (m_gain_third != {1'b1, {(SAMPLE_BITS-1){1'b0}}}),
        "gain magnitude exceeds saturation limit")
    `VBT_ASSERT_IMPL(a_inside_nonzero, m_valid && m_inside_region,
        (m_gain_first | m_gain_second | m_gain_third) != '0,
        "inside word has all gains zero")
    `VBT_ASSERT_NEXT(a_stall_holds_pipe, m_valid && !m_ready,
        $stable(dv_valid) && $stable(dv_quo),
        "pipeline moved during stall")
endmodule
`default_nettype wire

/* sim/tb_vbap_triplet_gains.sv */
// Self-checking testbench for the triplet panning gain block
`default_nettype none
module tb_vbap_triplet_gains import vbt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COEF_BITS_DEF;
    localparam int SB = SAMPLE_BITS_DEF;
    localparam int FRAC = (SB - 1) + (CB - 4);
    localparam int LATENCY = SB + 40;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [SB-1:0] x;
        logic signed [SB-1:0] y;
        logic signed [SB-1:0] z;
    } dir_t;

    typedef struct packed {
        logic signed [SB-1:0] g0;
        logic signed [SB-1:0] g1;
        logic signed [SB-1:0] g2;
        logic                 in_region;
    } gains_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [3*CB-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SB-1:0] s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SB-1:0] m_gain_first, m_gain_second, m_gain_third;
    logic m_inside_region;

    vbap_triplet_gains uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor copy of the registers
    logic [3*CB-1:0] row_x, row_y, row_z;
    logic [14:0] tol_reg;

    dir_t   pending_dirs[$];
    gains_t expected_gains[$];
    int     send_idle_pct = 0, recv_idle_pct = 0;
    bit     recv_hold = 0;
    bit     in_taken = 0;
    int     errors = 0;
    longint cycles = 0;

    function automatic longint coef_of(logic [3*CB-1:0] row, int i);
        logic signed [CB-1:0] c;
        c = row[i*CB +: CB];
        return longint'(c);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic gains_t panning_gains(dir_t d);
        gains_t g;
        longint rawg[3];
        logic [63:0] mag[3];
        logic [63:0] maxm, sum, n, q;
        longint tol;
        int len;
        g = '0;
        maxm = 0;
        tol = longint'(tol_reg) <<< (FRAC - 15);
        for (int i = 0; i < 3; i++) begin
            rawg[i] = longint'(d.x) * coef_of(row_x, i) + longint'(d.y) * coef_of(row_y, i)
                    + longint'(d.z) * coef_of(row_z, i);
            if (rawg[i] < -tol) return g;
            mag[i] = rawg[i] < 0 ? -rawg[i] : rawg[i];
            if (mag[i] > maxm) maxm = mag[i];
        end
        if (maxm == 0) return g;
        len = 0;
        while ((maxm >> len) != 0) len++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (len > NORM_TOP) mag[i] >>= (len - NORM_TOP);
            else mag[i] <<= (NORM_TOP - len);
            sum += mag[i] * mag[i];
        end
        n = root64(sum);
        if (n == 0) return g;
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << SB) + n) / (n << 1);
            if (q > (64'd1 << (SB - 1)) - 1) q = (64'd1 << (SB - 1)) - 1;
            if (rawg[i] < 0) q = -q;
            case (i)
                0: g.g0 = q[SB-1:0];
                1: g.g1 = q[SB-1:0];
                default: g.g2 = q[SB-1:0];
            endcase
        end
        g.in_region = 1'b1;
        return g;
    endfunction

    function automatic void add_dir(dir_t d);
        pending_dirs = {pending_dirs, d};
    endfunction

    // driver: present words at the falling edge, hold each until it is taken
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (pending_dirs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_dir_x <= pending_dirs[0].x;
                    s_dir_y <= pending_dirs[0].y;
                    s_dir_z <= pending_dirs[0].z;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            in_taken = 1'b0;
            m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // accepted inputs feed the predictor and advance the pending queue
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_gains = {expected_gains, panning_gains({s_dir_x, s_dir_y, s_dir_z})};
            void'(pending_dirs.pop_front());
            in_taken = 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        gains_t e;
        cycles++;
        if (aresetn && m_valid && m_ready) begin
            if (expected_gains.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = expected_gains.pop_front();
                if (m_gain_first !== e.g0) begin
                    $error("gain_first exp %0d got %0d", e.g0, m_gain_first); errors++;
                end
                if (m_gain_second !== e.g1) begin
                    $error("gain_second exp %0d got %0d", e.g1, m_gain_second); errors++;
                end
                if (m_gain_third !== e.g2) begin
                    $error("gain_third exp %0d got %0d", e.g2, m_gain_third); errors++;
                end
                if (m_inside_region !== e.in_region) begin
                    $error("inside_region exp %0d got %0d", e.in_region, m_inside_region);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_vbap_triplet_gains failed");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [3*CB-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ROW_X: row_x = val;
            REG_ROW_Y: row_y = val;
            REG_ROW_Z: row_z = val;
            default:   tol_reg = val[14:0];
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending_dirs.size() > 0 || expected_gains.size() > 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [CB-1:0] rand_coef();
        return $urandom_range(3) == 0 ? CB'($urandom) : CB'($signed(16'($urandom)) >>> 1);
    endfunction

    function automatic logic [3*CB-1:0] rand_row();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    // mostly random vectors halved in range, some raw noise
    function automatic dir_t rand_dir();
        dir_t d;
        d = {16'($urandom), 16'($urandom), 16'($urandom)};
        if ($urandom_range(3) != 0) begin
            d.x = d.x >>> 1;
            d.y = d.y >>> 1;
            d.z = d.z >>> 1;
        end
        return d;
    endfunction

    task automatic load_matrix(logic [3*CB-1:0] rx, ry, rz, logic [14:0] t);
        write_reg(REG_ROW_X, rx);
        write_reg(REG_ROW_Y, ry);
        write_reg(REG_ROW_Z, rz);
        write_reg(REG_TOL, {{(3*CB-15){1'b0}}, t});
    endtask

    localparam logic [CB-1:0] ONE = CB'(1 << (CB - 4));
    localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

    initial begin
        row_x = '0; row_y = '0; row_z = '0; tol_reg = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset matrix: zero norm
        add_dir({16'sd12000, -16'sd5000, 16'sd100});
        drain();

        // identity matrix: axes, full scale, small negatives, outside
        load_matrix({{2{CB'(0)}}, ONE}, {CB'(0), ONE, CB'(0)}, {ONE, {2{CB'(0)}}}, 15'd1000);
        add_dir({16'sh7fff, 16'sd0, 16'sd0});
        add_dir({16'sh8000, 16'sd0, 16'sd0});
        add_dir({16'sd0, 16'sh7fff, 16'sd0});
        add_dir({16'sd0, 16'sd0, 16'sh7fff});
        add_dir({16'sd18918, 16'sd18918, 16'sd18918});
        add_dir({-16'sd500, 16'sd20000, 16'sd20000});
        add_dir({-16'sd1001, 16'sd20000, 16'sd20000});
        add_dir({16'sd0, 16'sd0, 16'sd0});
        add_dir({16'sd1, 16'sd0, 16'sd0});
        add_dir({16'sh8000, 16'sh8000, 16'sh8000});
        add_dir({16'sh7fff, 16'sh7fff, 16'sh7fff});
        drain();

        // extreme coefficients, maximum tolerance
        load_matrix({3{CMAX}}, {3{CMIN}}, {CMAX, CMIN, CMAX}, 15'h7fff);
        add_dir({16'sh7fff, 16'sh8000, 16'sh7fff});
        add_dir({16'sh8000, 16'sh7fff, 16'sh8000});
        add_dir({16'sh7fff, 16'sh7fff, 16'sh8000});
        add_dir({16'sd1, -16'sd1, 16'sd1});
        add_dir({16'sh5555, 16'shaaaa, 16'sh5555});
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 16 : phase == 1 ? 58 : 0;
            recv_idle_pct = phase == 0 ? 58 : phase == 1 ? 16 : 0;
            for (int b = 0; b < 4; b++) begin
                int nb;
                nb = (phase == 2 && b == 1) ? 120 : 36;
                load_matrix(rand_row(), rand_row(), rand_row(),
                            b == 0 ? 15'd0 : b == 3 ? 15'h7fff : 15'($urandom));
                for (int k = 0; k < nb; k++) add_dir(rand_dir());
                if (phase == 2 && b == 1) begin
                    // long receiver hold while words keep coming
                    recv_hold = 1;
                    repeat (300) @(posedge aclk);
                    recv_hold = 0;
                end
                drain();
            end
        end

        drain();
        if (errors == 0)
            $display("tb_vbap_triplet_gains passed");
        else
            $display("tb_vbap_triplet_gains failed");
        $finish;
    end
endmodule
`default_nettype wire
